// ===== sv/crc8pd_pkg.sv =====
package crc8pd_pkg;

	localparam logic [7:0] CRC_POLY         = 8'h07;
	localparam logic [7:0] RST_START_BYTE   = 8'hAA;
	localparam logic [7:0] RST_MAX_LENGTH   = 8'd64;
	localparam logic [7:0] RST_COMMAND_TYPE = 8'h01;
	localparam logic [7:0] CMD_MIN_LENGTH   = 8'd3;

	// configuration register indexes
	localparam logic [1:0] REG_START_BYTE   = 2'd0;
	localparam logic [1:0] REG_MAX_LENGTH   = 2'd1;
	localparam logic [1:0] REG_COMMAND_TYPE = 2'd2;

	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_CRC_ERR = 2'd1,
		STATUS_LEN_ERR = 2'd2
	} status_t;

	typedef enum logic [4:0] {
		PH_HUNT    = 5'b00001,
		PH_TYPE    = 5'b00010,
		PH_LENGTH  = 5'b00100,
		PH_PAYLOAD = 5'b01000,
		PH_CRC     = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [7:0] start_byte;
		logic [7:0] max_payload_length;
		logic [7:0] command_type;
	} cfg_t;

	typedef struct packed {
		logic [7:0]  frame_type;
		status_t     frame_status;
		logic        is_command;
		logic [15:0] command_id;
		logic [7:0]  command_code;
		logic [15:0] frame_count;
	} res_t;

	// byte-wide crc-8, msb first, no reflection
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== sv/crc8pd_cfg.sv =====
module crc8pd_cfg
	import crc8pd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	output cfg_t       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_byte         <= RST_START_BYTE;
			cfg_q.max_payload_length <= RST_MAX_LENGTH;
			cfg_q.command_type       <= RST_COMMAND_TYPE;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_START_BYTE:   cfg_q.start_byte         <= cfg_data;
				REG_MAX_LENGTH:   cfg_q.max_payload_length <= cfg_data;
				REG_COMMAND_TYPE: cfg_q.command_type       <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== sv/crc8pd_parser.sv =====
module crc8pd_parser
	import crc8pd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       consume,
	input  logic [7:0] byte_in,
	input  cfg_t       cfg,
	output logic       res_valid,
	output res_t       res
);

	phase_t      phase_q, phase_d;
	logic [7:0]  type_q, type_d;
	logic [7:0]  length_q, length_d;
	logic [7:0]  index_q, index_d;
	logic [7:0]  crc_q, crc_d;
	logic [15:0] cmd_id_q, cmd_id_d;
	logic [7:0]  cmd_code_q, cmd_code_d;
	logic [15:0] good_frames_q, good_frames_d;
	logic [7:0]  crc_next;

	assign crc_next = crc8_update(crc_q, byte_in);

	always_comb begin
		phase_d       = phase_q;
		type_d        = type_q;
		length_d      = length_q;
		index_d       = index_q;
		crc_d         = crc_q;
		cmd_id_d      = cmd_id_q;
		cmd_code_d    = cmd_code_q;
		good_frames_d = good_frames_q;
		res_valid     = 1'b0;
		res.frame_status = STATUS_OK;
		res.is_command   = 1'b0;
		case (phase_q)
			PH_HUNT: begin
				if (byte_in == cfg.start_byte) begin
					crc_d      = crc8_update(8'h00, byte_in);
					type_d     = 8'h00;
					length_d   = 8'h00;
					index_d    = 8'h00;
					cmd_id_d   = 16'h0000;
					cmd_code_d = 8'h00;
					phase_d    = PH_TYPE;
				end
			end
			PH_TYPE: begin
				type_d  = byte_in;
				crc_d   = crc_next;
				phase_d = PH_LENGTH;
			end
			PH_LENGTH: begin
				length_d = byte_in;
				if (byte_in > cfg.max_payload_length) begin
					phase_d          = PH_HUNT;
					res_valid        = 1'b1;
					res.frame_status = STATUS_LEN_ERR;
				end else begin
					crc_d   = crc_next;
					index_d = 8'h00;
					phase_d = (byte_in == 8'h00) ? PH_CRC : PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				crc_d = crc_next;
				case (index_q)
					8'd0:    cmd_id_d[15:8] = byte_in;
					8'd1:    cmd_id_d[7:0]  = byte_in;
					8'd2:    cmd_code_d     = byte_in;
					default: ;
				endcase
				index_d = index_q + 8'd1;
				if (index_d >= length_q) begin
					phase_d = PH_CRC;
				end
			end
			PH_CRC: begin
				phase_d   = PH_HUNT;
				res_valid = 1'b1;
				if (byte_in != crc_q) begin
					res.frame_status = STATUS_CRC_ERR;
				end else begin
					good_frames_d  = good_frames_q + 16'd1;
					res.is_command = (type_q == cfg.command_type) &&
						(length_q >= CMD_MIN_LENGTH);
				end
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
		res.frame_type   = type_q;
		res.command_id   = res.is_command ? cmd_id_q : 16'h0000;
		res.command_code = res.is_command ? cmd_code_q : 8'h00;
		res.frame_count  = good_frames_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_HUNT;
			type_q        <= '0;
			length_q      <= '0;
			index_q       <= '0;
			crc_q         <= '0;
			cmd_id_q      <= '0;
			cmd_code_q    <= '0;
			good_frames_q <= '0;
		end else if (consume) begin
			phase_q       <= phase_d;
			type_q        <= type_d;
			length_q      <= length_d;
			index_q       <= index_d;
			crc_q         <= crc_d;
			cmd_id_q      <= cmd_id_d;
			cmd_code_q    <= cmd_code_d;
			good_frames_q <= good_frames_d;
		end
	end

	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.frame_status == STATUS_OK || res.frame_status == STATUS_CRC_ERR ||
			res.frame_status == STATUS_LEN_ERR))
		else $error("illegal frame status");

	a_cmd_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.is_command) |-> (res.frame_status == STATUS_OK && phase_q == PH_CRC))
		else $error("command flagged on a bad frame");

	a_count_good: assert property (@(posedge clk) disable iff (!arst_n)
		(consume && res_valid && res.frame_status == STATUS_OK) |=>
			(good_frames_q == $past(good_frames_q) + 16'd1))
		else $error("good frame counter did not advance");

endmodule

// ===== sv/crc8_packet_deframer_unit.sv =====
// crc8 packet deframer
// input channel: in_valid / in_ready / rx_byte, one received byte per transfer;
// the block hunts for start_byte, then reads type, length, payload and a crc-8
// byte (poly 0x07, init 0, over start, type, length and payload)
// output channel: out_valid / out_ready with one result per finished or
// rejected frame (type, status, command fields, good frame count)
// config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; always
// ready, index 0 start byte, 1 max payload length, 2 command type, 3 ignored
// throughput: one byte per cycle while results are taken
// path: a byte accepted into the input register is parsed from there and
// its result is loaded into the output register when that byte is consumed
// the input register and the output register decouple the two sides, so a
// byte is taken while a finished result still waits
// when the receiver stalls with a result pending, the input register holds
// one more byte and in_ready drops until the result transfer happens
// reset: config returns to 0xAA / 64 / 0x01, the parser hunts for a start
// byte, the good frame count clears and both registers are emptied
module crc8_packet_deframer_unit
	import crc8pd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  frame_type,
	output logic [1:0]  frame_status,
	output logic        is_command,
	output logic [15:0] command_id,
	output logic [7:0]  command_code,
	output logic [15:0] frame_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	cfg_t       cfg;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       consume;
	logic       res_valid;
	res_t       res;
	logic       out_valid_q;
	res_t       res_q;

	// config writes land at once
	assign cfg_ready = 1'b1;

	crc8pd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// the held byte is parsed when the output register can take its result
	assign consume  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || consume;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	crc8pd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.consume   (consume),
		.byte_in   (byte_s1),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res       (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (consume && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign frame_type   = res_q.frame_type;
	assign frame_status = res_q.frame_status;
	assign is_command   = res_q.is_command;
	assign command_id   = res_q.command_id;
	assign command_code = res_q.command_code;
	assign frame_count  = res_q.frame_count;

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(consume && res_valid) |=> out_valid_q)
		else $error("result lost on its way to the output register");

	a_byte_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !consume) |=> (valid_s1 && $stable(byte_s1)))
		else $error("held byte dropped while the output was stalled");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !consume)
		else $error("parser advanced over a pending result");

endmodule

// ===== tb/crc8_packet_deframer_unit_tb.sv =====
module crc8_packet_deframer_unit_tb
	import crc8pd_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	// generous cycle budget for the whole run, far above the slowest correct run
	localparam int CYCLE_LIMIT = 400000;
	// edges a byte needs to leave the block, plus margin
	localparam int DRAIN_CYCLES = 8;
	localparam int BYTE_TARGET = 1450;
	// index 3 has no register behind it
	localparam logic [1:0] REG_UNUSED = 2'd3;

	// predictor of the deframer plus the queue of frames it has announced
	class frame_scoreboard;
		logic [7:0]  start_byte;
		logic [7:0]  max_len;
		logic [7:0]  cmd_type;
		phase_t      ph;
		logic [7:0]  typ;
		logic [7:0]  len;
		logic [7:0]  idx;
		logic [7:0]  crc;
		logic [15:0] cid;
		logic [7:0]  ccode;
		logic [15:0] good;
		res_t        expected_frames[$];
		int          errors;

		function new();
			start_byte = RST_START_BYTE;
			max_len    = RST_MAX_LENGTH;
			cmd_type   = RST_COMMAND_TYPE;
			ph    = PH_HUNT;
			typ   = '0;
			len   = '0;
			idx   = '0;
			crc   = '0;
			cid   = '0;
			ccode = '0;
			good  = '0;
			errors = 0;
		endfunction

		// msb-first crc-8, one bit per iteration
		function logic [7:0] crc_step(logic [7:0] c, logic [7:0] b);
			logic fb;
			c = c ^ b;
			for (int k = 0; k < 8; k++) begin
				fb = c[7];
				c  = c << 1;
				if (fb) begin
					c = c ^ CRC_POLY;
				end
			end
			return c;
		endfunction

		function void set_register(logic [1:0] index, logic [7:0] value);
			case (index)
				REG_START_BYTE:   start_byte = value;
				REG_MAX_LENGTH:   max_len    = value;
				REG_COMMAND_TYPE: cmd_type   = value;
				default: ;
			endcase
		endfunction

		function void queue_result(status_t st, bit cmd);
			res_t r;
			r.frame_type   = typ;
			r.frame_status = st;
			r.is_command   = cmd;
			r.command_id   = cmd ? cid : 16'h0000;
			r.command_code = cmd ? ccode : 8'h00;
			r.frame_count  = good;
			expected_frames.push_back(r);
		endfunction

		// advance the parser by one accepted byte
		function void take_byte(logic [7:0] b);
			case (ph)
				PH_TYPE: begin
					typ = b;
					crc = crc_step(crc, b);
					ph  = PH_LENGTH;
				end
				PH_LENGTH: begin
					len = b;
					if (b > max_len) begin
						ph = PH_HUNT;
						queue_result(STATUS_LEN_ERR, 1'b0);
					end else begin
						crc = crc_step(crc, b);
						idx = '0;
						ph  = (b == 8'h00) ? PH_CRC : PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					crc = crc_step(crc, b);
					if (idx == 8'd0) begin
						cid[15:8] = b;
					end else if (idx == 8'd1) begin
						cid[7:0] = b;
					end else if (idx == 8'd2) begin
						ccode = b;
					end
					idx = idx + 8'd1;
					if (idx >= len) begin
						ph = PH_CRC;
					end
				end
				PH_CRC: begin
					ph = PH_HUNT;
					if (b != crc) begin
						queue_result(STATUS_CRC_ERR, 1'b0);
					end else begin
						good = good + 16'd1;
						queue_result(STATUS_OK, (typ == cmd_type) && (len >= CMD_MIN_LENGTH));
					end
				end
				default: begin
					ph = PH_HUNT;
					if (b == start_byte) begin
						crc   = crc_step(8'h00, b);
						typ   = '0;
						len   = '0;
						idx   = '0;
						cid   = '0;
						ccode = '0;
						ph    = PH_TYPE;
					end
				end
			endcase
		endfunction

		function void cmp_field(string fname, logic [15:0] want, logic [15:0] seen);
			if (seen !== want) begin
				$display("%0t mismatch %s: expected %h, actual %h", $time, fname, want, seen);
				errors++;
			end
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (expected_frames.size() == 0) begin
				$display("%0t unexpected result: expected none, actual type %h status %h",
					$time, got.frame_type, got.frame_status);
				errors++;
				return;
			end
			want = expected_frames.pop_front();
			cmp_field("frame_type",   16'(want.frame_type),   16'(got.frame_type));
			cmp_field("frame_status", 16'(want.frame_status), 16'(got.frame_status));
			cmp_field("is_command",   16'(want.is_command),   16'(got.is_command));
			cmp_field("command_id",   want.command_id,        got.command_id);
			cmp_field("command_code", 16'(want.command_code), 16'(got.command_code));
			cmp_field("frame_count",  want.frame_count,       got.frame_count);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  frame_type;
	logic [1:0]  frame_status;
	logic        is_command;
	logic [15:0] command_id;
	logic [7:0]  command_code;
	logic [15:0] frame_count;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [7:0]  cfg_data;

	frame_scoreboard sb = new();

	int cycles;
	int bytes_sent;
	int burst_left;
	bit gaps_on;

	crc8_packet_deframer_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.frame_type   (frame_type),
		.frame_status (frame_status),
		.is_command   (is_command),
		.command_id   (command_id),
		.command_code (command_code),
		.frame_count  (frame_count),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// 10 ns clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// cycle counter doubles as the watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// receiver stall pattern: the mode follows the cycle counter, in this order:
	// always ready, coin flip, one in four, and long stalls
	always @(negedge clk) begin
		case ((cycles >> 7) & 3)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			2: out_ready <= ((cycles % 4) == 0);
			default: out_ready <= ((cycles % 24) < 4);
		endcase
	end

	// monitor: every transfer on the input and output channels is seen here at the rising edge
	always @(posedge clk) begin
		res_t got;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got.frame_type   = frame_type;
				got.frame_status = status_t'(frame_status);
				got.is_command   = is_command;
				got.command_id   = command_id;
				got.command_code = command_code;
				got.frame_count  = frame_count;
				sb.check_result(got);
			end
			// prediction runs as the byte transfer happens
			if (in_valid && in_ready) begin
				sb.take_byte(rx_byte);
			end
		end
	end

	// one byte transfer; the sender works in bursts with random gaps between them when gaps_on is set
	// returns at the edge of the transfer with valid still high
	task automatic send_byte(input logic [7:0] b);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = gaps_on ? $urandom_range(1, 8) : 0;
			repeat (gap) begin
				in_valid <= 1'b0;
				@(negedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
	endtask

	task automatic idle_input();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// pause the sender until every announced frame has come out, then let the
	// input register empty of bytes that cause no result
	task automatic wait_idle();
		idle_input();
		while (sb.expected_frames.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// register write, only called while the block is idle
	task automatic write_reg(input logic [1:0] index, input logic [7:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		sb.set_register(index, value);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// whole frame with the current start byte; fill < 0 gives random payload,
	// keep < 0 sends everything, else only the first keep bytes (frame left open)
	task automatic send_frame(input logic [7:0] typ, input int len, input bit bad_crc,
		input int fill, input int keep);
		logic [7:0] fb[$];
		logic [7:0] c;
		int n;
		fb.push_back(sb.start_byte);
		fb.push_back(typ);
		fb.push_back(8'(len));
		for (int i = 0; i < len; i++) begin
			fb.push_back((fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill));
		end
		c = 8'h00;
		foreach (fb[i]) begin
			c = sb.crc_step(c, fb[i]);
		end
		if (bad_crc) begin
			c = c ^ 8'(1 << $urandom_range(0, 7));
		end
		fb.push_back(c);
		n = (keep < 0 || keep > fb.size()) ? fb.size() : keep;
		for (int i = 0; i < n; i++) begin
			send_byte(fb[i]);
		end
	endtask

	// start, type and a length above the maximum
	task automatic send_oversize(input logic [7:0] typ, input logic [7:0] len);
		send_byte(sb.start_byte);
		send_byte(typ);
		send_byte(len);
	endtask

	// one randomly chosen piece of traffic, mostly well formed frames
	task automatic random_traffic();
		int r;
		int cap;
		int len;
		logic [7:0] typ;
		r   = $urandom_range(0, 99);
		cap = int'(sb.max_len);
		if ($urandom_range(0, 19) == 0) begin
			len = $urandom_range(0, cap);
		end else begin
			len = $urandom_range(0, (cap < 8) ? cap : 8);
		end
		// half the frames carry the command type
		typ = $urandom_range(0, 1) ? sb.cmd_type : 8'($urandom_range(0, 255));
		if (r < 60) begin
			send_frame(typ, len, 1'b0, -1, -1);
		end else if (r < 72) begin
			send_frame(typ, len, 1'b1, -1, -1);
		end else if (r < 80 && sb.max_len != 8'hFF) begin
			send_oversize(typ, 8'($urandom_range(int'(sb.max_len) + 1, 255)));
		end else if (r < 90) begin
			// line noise, may itself open a frame
			repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)));
		end else begin
			// broken frame: the following bytes simply continue it
			send_frame(typ, len, 1'b0, -1, $urandom_range(1, len + 3));
		end
	endtask

	initial begin
		int phase_no;
		int budget;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		rx_byte    = 8'h00;
		out_ready  = 1'b0;
		cfg_valid  = 1'b0;
		cfg_index  = REG_START_BYTE;
		cfg_data   = 8'h00;
		cycles     = 0;
		bytes_sent = 0;
		burst_left = 0;
		gaps_on    = 1'b1;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part with the reset configuration
		send_byte(8'h00);                           // ignored while hunting
		send_byte(8'hFF);
		send_frame(RST_COMMAND_TYPE, 3, 1'b0, 8'hFF, -1); // command, all-ones payload
		send_frame(8'hFF, 0, 1'b0, -1, -1);              // empty payload, crc right after length
		send_frame(RST_COMMAND_TYPE, 2, 1'b0, 8'h00, -1); // too short for a command
		send_frame(RST_COMMAND_TYPE, 3, 1'b1, -1, -1);    // crc mismatch
		send_oversize(8'h00, 8'd65);                      // one above the maximum
		wait_idle();

		// register without a backing field
		write_reg(REG_UNUSED, 8'h5A);

		// random part in phases, each with its own configuration
		phase_no = 0;
		while (bytes_sent < BYTE_TARGET) begin
			case (phase_no)
				0: ;
				1: begin
					write_reg(REG_START_BYTE, 8'h00);
					write_reg(REG_MAX_LENGTH, 8'h00);
					write_reg(REG_COMMAND_TYPE, 8'h00);
				end
				2: begin
					write_reg(REG_START_BYTE, 8'hFF);
					write_reg(REG_MAX_LENGTH, 8'hFF);
					write_reg(REG_COMMAND_TYPE, 8'hFF);
				end
				default: begin
					write_reg(REG_START_BYTE, 8'($urandom_range(0, 255)));
					write_reg(REG_MAX_LENGTH, 8'($urandom_range(3, 20)));
					write_reg(REG_COMMAND_TYPE, 8'($urandom_range(0, 255)));
					if ($urandom_range(0, 2) == 0) begin
						write_reg(REG_UNUSED, 8'($urandom_range(0, 255)));
					end
				end
			endcase
			// some phases run without sender gaps at all
			gaps_on = ($urandom_range(0, 3) != 0);
			budget  = bytes_sent + 180;
			while (bytes_sent < budget) begin
				random_traffic();
			end
			// sender pauses until every expected frame is out before reconfiguring
			wait_idle();
			phase_no++;
		end

		wait_idle();
		if (sb.errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
